// ----- rtl/sba_pkg.sv -----
// Package for the slot bitmap allocator: map geometry, action codes and
// sequencer states. No dependencies; used by slot_bitmap_allocator_core.
`default_nettype none

package sba_pkg;

  // Map geometry. One map byte holds eight slots.
  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned MAP_BYTES  = (SLOT_COUNT + 7) / 8;
  localparam int unsigned ADDR_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  // Slot positions inside the core are wide enough for a range end
  // (start plus count, up to 510) and for any slot below SLOT_COUNT.
  localparam int unsigned POS_W = 11;
  localparam int unsigned BN_W  = POS_W - 3;

  // Action codes carried by an input item.
  typedef enum logic [2:0] {
    ACT_FIND      = 3'd0,
    ACT_MARK      = 3'd1,
    ACT_CLR_RANGE = 3'd2,
    ACT_CLR_ALL   = 3'd3,
    ACT_LOAD      = 3'd4
  } action_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_MARK,
    S_CLR,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/slot_bitmap_allocator_core.sv -----
// Slot bitmap allocator core: used/free map of slots in a byte-wide memory,
// worked by a read-modify-write sequencer. Depends on sba_pkg.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   action, slot_index, clear_count,
//                                                 byte_index, byte_value
//   out      source     out_valid_o / out_stall_i free_slot, table_full
//   cfg      sink       cfg_we_i                  cfg_wdata_i (slot_limit)
//
// Work per item: find free fetches map bytes in order until a free slot or the
// last byte (at most MAP_BYTES); clear range reads and writes back each byte it
// covers; mark used reads and writes back one byte; clear all, load byte and
// unused codes need no map read.
// The scan rate is set by the single read port of the map memory, one byte a cycle.
// Reset clears one valid flop per map byte, so the map reads all free at once;
// there is no clearing pass. A new item is taken while a result waits at the
// output; the sequencer holds its finished result until the output is free.
`default_nettype none

module slot_bitmap_allocator_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input item channel.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  input  wire logic [7:0] slot_index_i,
  input  wire logic [7:0] clear_count_i,
  input  wire logic [4:0] byte_index_i,
  input  wire logic [7:0] byte_value_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      free_slot_o,
  output logic            table_full_o,
  // Configuration write port (slot_limit).
  input  wire logic       cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i
);

  localparam int unsigned AW = sba_pkg::ADDR_W;
  localparam int unsigned PW = sba_pkg::POS_W;
  localparam int unsigned BW = sba_pkg::BN_W;
  localparam int unsigned NB = sba_pkg::MAP_BYTES;

  sba_pkg::state_e state_q, state_d;

  // Map memory and per-byte valid flags.
  logic [7:0]    mem_q [NB];
  logic [NB-1:0] valid_q, valid_d;

  // Read pipeline.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          rd_ok_q;
  logic          rd_vld_q;
  logic [7:0]    rd_data_q;
  logic [BW-1:0] rd_byte_q;

  // Write port.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // Item context.
  logic [PW-1:0] start_q, start_d;
  logic [PW-1:0] end_q, end_d;
  logic [BW-1:0] last_q, last_d;
  logic [2:0]    bit_q, bit_d;
  logic [BW-1:0] ptr_q, ptr_d;
  logic          more_q, more_d;
  logic [7:0]    res_slot_q, res_slot_d;
  logic          res_full_q, res_full_d;

  // Output register and configuration.
  logic          out_valid_q, out_valid_d;
  logic [7:0]    free_slot_q, free_slot_d;
  logic          table_full_q, table_full_d;
  logic [8:0]    slot_limit_q;

  // Derived signals.
  logic          in_xfer;
  logic          out_free;
  logic [PW-1:0] in_start;
  logic [PW-1:0] in_end;
  logic [PW-1:0] in_last_pos;
  logic [BW-1:0] in_last_b;
  logic          idx_ok;
  logic [7:0]    rd_word;
  logic [7:0]    scan_word;
  logic [7:0]    clr_mask;
  logic [2:0]    hit_bit;
  logic          hit;
  logic          scan_end;
  logic [PW-1:0] hit_pos;
  logic          hit_full;

  assign in_stall_o   = (state_q != sba_pkg::S_IDLE);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign free_slot_o  = free_slot_q;
  assign table_full_o = table_full_q;

  // Input decode: range bounds and the last byte a clear range touches.
  assign in_start    = PW'(slot_index_i);
  assign in_end      = in_start + PW'(clear_count_i);
  assign in_last_pos = in_end - PW'(1);
  assign idx_ok      = in_start < PW'(sba_pkg::SLOT_COUNT);
  assign in_last_b   = (in_last_pos[PW-1:3] > BW'(NB - 1)) ? BW'(NB - 1)
                                                           : in_last_pos[PW-1:3];

  // A byte never written reads as all free.
  assign rd_word = rd_vld_q ? rd_data_q : 8'h00;

  // Per-bit masks of the byte just read: padding past the table and clear range.
  always_comb begin
    logic [PW-1:0] pos;
    scan_word = rd_word;
    clr_mask  = 8'h00;
    for (int j = 0; j < 8; j++) begin
      pos = {rd_byte_q, 3'(j)};
      if (pos >= PW'(sba_pkg::SLOT_COUNT)) begin
        scan_word[j] = 1'b1;
      end
      clr_mask[j] = (pos >= start_q) && (pos < end_q) &&
                    (pos < PW'(sba_pkg::SLOT_COUNT));
    end
  end

  // Lowest free bit of the scanned byte.
  always_comb begin
    hit_bit = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!scan_word[j]) begin
        hit_bit = 3'(j);
      end
    end
  end

  assign hit      = rd_ok_q && (scan_word != 8'hFF);
  assign scan_end = rd_ok_q && (rd_byte_q == BW'(NB - 1));
  assign hit_pos  = {rd_byte_q, hit_bit};
  assign hit_full = (hit_pos >= PW'(slot_limit_q)) || (hit_pos > PW'(255));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sba_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (action_i)
            sba_pkg::ACT_FIND:      state_d = sba_pkg::S_FIND;
            sba_pkg::ACT_MARK:      state_d = idx_ok ? sba_pkg::S_MARK : sba_pkg::S_DONE;
            sba_pkg::ACT_CLR_RANGE: begin
              state_d = (idx_ok && (clear_count_i != 8'd0)) ? sba_pkg::S_CLR
                                                            : sba_pkg::S_DONE;
            end
            default:                state_d = sba_pkg::S_DONE;
          endcase
        end
      end
      sba_pkg::S_FIND: begin
        if (hit || scan_end) begin
          state_d = sba_pkg::S_DONE;
        end
      end
      sba_pkg::S_MARK: begin
        state_d = sba_pkg::S_DONE;
      end
      sba_pkg::S_CLR: begin
        if (rd_ok_q && (rd_byte_q == last_q)) begin
          state_d = sba_pkg::S_DONE;
        end
      end
      sba_pkg::S_DONE: begin
        if (out_free) begin
          state_d = sba_pkg::S_IDLE;
        end
      end
      default: state_d = sba_pkg::S_IDLE;
    endcase
  end

  // Memory accesses, item context and result.
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = ptr_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = rd_byte_q[AW-1:0];
    wr_data      = rd_word;
    valid_d      = valid_q;
    start_d      = start_q;
    end_d        = end_q;
    last_d       = last_q;
    bit_d        = bit_q;
    ptr_d        = ptr_q;
    more_d       = more_q;
    res_slot_d   = res_slot_q;
    res_full_d   = res_full_q;
    out_valid_d  = out_valid_q && out_stall_i;
    free_slot_d  = free_slot_q;
    table_full_d = table_full_q;

    case (state_q)
      sba_pkg::S_IDLE: begin
        if (in_xfer) begin
          start_d    = in_start;
          end_d      = in_end;
          last_d     = in_last_b;
          bit_d      = slot_index_i[2:0];
          ptr_d      = BW'(0);
          more_d     = 1'b1;
          res_slot_d = 8'd0;
          res_full_d = 1'b0;
          case (action_i)
            sba_pkg::ACT_MARK: begin
              if (idx_ok) begin
                rd_en   = 1'b1;
                rd_addr = in_start[AW+2:3];
              end
            end
            sba_pkg::ACT_CLR_RANGE: begin
              ptr_d = in_start[PW-1:3];
            end
            sba_pkg::ACT_CLR_ALL: begin
              valid_d = '0;
            end
            sba_pkg::ACT_LOAD: begin
              if (32'(byte_index_i) < NB) begin
                wr_en   = 1'b1;
                wr_addr = AW'(byte_index_i);
                wr_data = byte_value_i;
              end
            end
            default: begin
            end
          endcase
        end
      end
      sba_pkg::S_FIND: begin
        // Fetch one byte a cycle, check the byte fetched the cycle before.
        if (more_q) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + BW'(1);
          more_d = (ptr_q != BW'(NB - 1));
        end
        if (hit) begin
          res_slot_d = hit_full ? 8'd0 : hit_pos[7:0];
          res_full_d = hit_full;
        end else if (scan_end) begin
          res_full_d = 1'b1;
        end
      end
      sba_pkg::S_MARK: begin
        wr_en   = 1'b1;
        wr_data = rd_word | (8'h01 << bit_q);
      end
      sba_pkg::S_CLR: begin
        // Read byte k+1 while byte k is written back.
        if (more_q) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + BW'(1);
          more_d = (ptr_q != last_q);
        end
        if (rd_ok_q) begin
          wr_en   = 1'b1;
          wr_data = rd_word & ~clr_mask;
        end
      end
      sba_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          free_slot_d  = res_slot_q;
          table_full_d = res_full_q;
        end
      end
      default: begin
      end
    endcase

    if (wr_en) begin
      valid_d[wr_addr] = 1'b1;
    end
  end

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_byte_q <= BW'(rd_addr);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sba_pkg::S_IDLE;
      valid_q      <= '0;
      rd_ok_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
      more_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      slot_limit_q <= 9'd256;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_ok_q     <= rd_en;
      rd_vld_q    <= valid_q[rd_addr];
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slot_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    end_q        <= end_d;
    last_q       <= last_d;
    bit_q        <= bit_d;
    ptr_q        <= ptr_d;
    res_slot_q   <= res_slot_d;
    res_full_q   <= res_full_d;
    free_slot_q  <= free_slot_d;
    table_full_q <= table_full_d;
  end

  // A write-back never meets a fetch of the same byte.
  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("map read and write hit the same byte");

  // After a transfer in, the block is busy in the following cycle.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // A new result only comes out of the result state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sba_pkg::S_DONE))
    else $error("result raised outside the result state");

  // Mark used always has its byte fetched when it writes back.
  a_mark_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sba_pkg::S_MARK) |-> rd_ok_q)
    else $error("mark used writes back without read data");

endmodule

`default_nettype wire

// ----- verif/tb_slot_bitmap_allocator_core.sv -----
// Self-checking testbench for slot_bitmap_allocator_core: a queue-fed driver, a
// monitor and an in-bench bitmap predictor. Depends on sba_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_slot_bitmap_allocator_core;

  // One request transfer and the result it produces.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] slot_index;
    logic [7:0] clear_count;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
  } alloc_req_t;

  typedef struct packed {
    logic [7:0] free_slot;
    logic       table_full;
  } alloc_rsp_t;

  localparam int unsigned ACT_CODE_MAX = 7;
  localparam int unsigned LIMIT_MAX    = 511;
  localparam int unsigned IDLE_MAX     = 15;
  localparam int unsigned RUN_ITEMS    = 178;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned TAIL_CYCLES  = 40;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [2:0] action_i      = '0;
  logic [7:0] slot_index_i  = '0;
  logic [7:0] clear_count_i = '0;
  logic [4:0] byte_index_i  = '0;
  logic [7:0] byte_value_i  = '0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] free_slot_o;
  logic       table_full_o;
  logic       cfg_we_i      = 1'b0;
  logic [8:0] cfg_wdata_i   = '0;

  // Predictor state: the used/free map and the slot limit.
  logic [7:0] slot_map_q [sba_pkg::MAP_BYTES] = '{default: '0};
  logic [8:0] slot_limit_q = 9'd256;

  alloc_req_t req_q [$];
  alloc_rsp_t rsp_q [$];
  alloc_req_t drive_req;
  int         gap_left     = 0;
  int         stall_left   = 0;
  int         mismatch_cnt = 0;
  bit         tail_quiet   = 1'b0;
  int         limit_plan [PHASES];

  slot_bitmap_allocator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .slot_index_i  (slot_index_i),
    .clear_count_i (clear_count_i),
    .byte_index_i  (byte_index_i),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .free_slot_o   (free_slot_o),
    .table_full_o  (table_full_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one request to the map and returns the result it yields.
  function automatic alloc_rsp_t next_alloc_result(alloc_req_t req);
    alloc_rsp_t rsp;
    bit         found;
    int         found_pos;
    int         range_end;
    rsp       = '0;
    found     = 1'b0;
    found_pos = 0;
    range_end = int'(req.slot_index) + int'(req.clear_count);
    case (req.action)
      sba_pkg::ACT_FIND: begin
        for (int pos = 0; pos < sba_pkg::SLOT_COUNT && !found; pos++) begin
          if (!slot_map_q[pos / 8][pos % 8]) begin
            found     = 1'b1;
            found_pos = pos;
          end
        end
        // A slot at or beyond the limit, or one too wide for the port, is full.
        if (!found || found_pos >= slot_limit_q || found_pos > 255) begin
          rsp.table_full = 1'b1;
        end else begin
          rsp.free_slot = found_pos[7:0];
        end
      end
      sba_pkg::ACT_MARK: begin
        if (req.slot_index < sba_pkg::SLOT_COUNT) begin
          slot_map_q[req.slot_index / 8][req.slot_index % 8] = 1'b1;
        end
      end
      sba_pkg::ACT_CLR_RANGE: begin
        for (int pos = int'(req.slot_index); pos < range_end; pos++) begin
          if (pos < sba_pkg::SLOT_COUNT) begin
            slot_map_q[pos / 8][pos % 8] = 1'b0;
          end
        end
      end
      sba_pkg::ACT_CLR_ALL: begin
        foreach (slot_map_q[b]) slot_map_q[b] = '0;
      end
      sba_pkg::ACT_LOAD: begin
        if (req.byte_index < sba_pkg::MAP_BYTES) begin
          slot_map_q[req.byte_index] = req.byte_value;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // Request with the given action; fields it does not use are random.
  function automatic alloc_req_t rand_req(logic [2:0] act);
    alloc_req_t req;
    req.action      = act;
    req.slot_index  = 8'($urandom_range(0, 255));
    req.clear_count = 8'($urandom_range(0, 255));
    req.byte_index  = 5'($urandom_range(0, 31));
    req.byte_value  = 8'($urandom_range(0, 255));
    return req;
  endfunction

  task automatic queue_req(logic [2:0] act, int sidx, int cnt, int bidx, int bval);
    alloc_req_t req;
    req.action      = act;
    req.slot_index  = 8'(sidx);
    req.clear_count = 8'(cnt);
    req.byte_index  = 5'(bidx);
    req.byte_value  = 8'(bval);
    req_q.push_back(req);
  endtask

  // Random run. Fill sequences pack the low map bytes so that finds reach deep
  // slots and the limit; the rest is a loose mix of every action.
  task automatic queue_alloc_run(int unsigned n);
    alloc_req_t  req;
    int unsigned start;
    int          r;
    int          k;
    start = req_q.size();
    while (req_q.size() - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        k = $urandom_range(0, 1) ? $urandom_range(0, sba_pkg::MAP_BYTES)
                                 : $urandom_range(0, 4);
        for (int b = 0; b < k; b++) begin
          queue_req(sba_pkg::ACT_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                    b, 8'hFF);
        end
        if (k < sba_pkg::MAP_BYTES && $urandom_range(0, 1)) begin
          req = rand_req(sba_pkg::ACT_LOAD);
          req.byte_index = 5'(k);
          req_q.push_back(req);
        end
        req_q.push_back(rand_req(sba_pkg::ACT_FIND));
        req = rand_req(sba_pkg::ACT_MARK);
        if (k < sba_pkg::MAP_BYTES) req.slot_index = 8'(8 * k + $urandom_range(0, 7));
        req_q.push_back(req);
        req_q.push_back(rand_req(sba_pkg::ACT_FIND));
      end else if (r < 38) begin
        req_q.push_back(rand_req(sba_pkg::ACT_FIND));
      end else if (r < 58) begin
        req = rand_req(sba_pkg::ACT_MARK);
        if ($urandom_range(0, 1)) req.slot_index = 8'($urandom_range(0, 31));
        req_q.push_back(req);
      end else if (r < 70) begin
        req = rand_req(sba_pkg::ACT_CLR_RANGE);
        if ($urandom_range(0, 3) != 0) req.clear_count = 8'($urandom_range(0, 16));
        req_q.push_back(req);
      end else if (r < 73) begin
        req_q.push_back(rand_req(sba_pkg::ACT_CLR_ALL));
      end else if (r < 86) begin
        req_q.push_back(rand_req(sba_pkg::ACT_LOAD));
      end else if (r < 90) begin
        req_q.push_back(rand_req(3'($urandom_range(int'(sba_pkg::ACT_LOAD) + 1,
                                                   ACT_CODE_MAX))));
      end else begin
        req_q.push_back(rand_req(sba_pkg::ACT_FIND));
      end
    end
  endtask

  // Returns once every request has been taken and every result has arrived.
  // Checked at the falling edge, after the driver and monitor have settled.
  task automatic wait_alloc_idle();
    @(negedge clk_i);
    while (req_q.size() != 0 || rsp_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  task automatic write_slot_limit(int value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= 9'(value);
    slot_limit_q  = 9'(value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
  endtask

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Request driver: predicts each accepted transfer, then presents the next
  // pending request or an idle burst.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rsp_q.push_back(next_alloc_result(drive_req));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          drive_req      = req_q.pop_front();
          action_i      <= drive_req.action;
          slot_index_i  <= drive_req.slot_index;
          clear_count_i <= drive_req.clear_count;
          byte_index_i  <= drive_req.byte_index;
          byte_value_i  <= drive_req.byte_value;
          in_valid_i    <= 1'b1;
          if (!tail_quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, IDLE_MAX);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result transfer and stalls in random bursts.
  always @(posedge clk_i) begin
    alloc_rsp_t exp_rsp;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rsp_q.size() == 0) begin
          note_mismatch($sformatf("result with none pending: free_slot %0d table_full %0b",
                                  free_slot_o, table_full_o));
        end else begin
          exp_rsp = rsp_q.pop_front();
          if (free_slot_o !== exp_rsp.free_slot) begin
            note_mismatch($sformatf("free_slot: expected %0d, got %0d",
                                    exp_rsp.free_slot, free_slot_o));
          end
          if (table_full_o !== exp_rsp.table_full) begin
            note_mismatch($sformatf("table_full: expected %0b, got %0b",
                                    exp_rsp.table_full, table_full_o));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!tail_quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, IDLE_MAX);
      end
    end
  end

  // Main sequence: directed requests at the reset limit, then random runs
  // over a series of limits, the last run without idling.
  initial begin
    limit_plan = '{0, 1, 255, 256, LIMIT_MAX, $urandom_range(2, 254),
                   $urandom_range(0, LIMIT_MAX), 256};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty map, then single marks and a range that runs past the table.
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    queue_req(sba_pkg::ACT_MARK, 0, 255, 31, 255);
    queue_req(sba_pkg::ACT_FIND, 255, 255, 31, 255);
    queue_req(sba_pkg::ACT_MARK, 255, 0, 0, 0);
    queue_req(sba_pkg::ACT_CLR_RANGE, 250, 255, 0, 0);
    queue_req(sba_pkg::ACT_LOAD, 0, 0, 0, 8'hFF);
    queue_req(sba_pkg::ACT_LOAD, 255, 255, 31, 8'hFF);
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    // Zero-length range, then a short range inside a full byte.
    queue_req(sba_pkg::ACT_CLR_RANGE, 0, 0, 0, 0);
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    queue_req(sba_pkg::ACT_CLR_RANGE, 3, 2, 0, 0);
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    queue_req(sba_pkg::ACT_LOAD, 255, 255, 0, 8'h00);
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    // Unused action codes leave the map alone and give a zero result.
    for (int c = int'(sba_pkg::ACT_LOAD) + 1; c <= ACT_CODE_MAX; c++) begin
      queue_req(3'(c), 255, 255, 31, 255);
    end
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    queue_req(sba_pkg::ACT_CLR_ALL, 255, 255, 31, 255);
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    queue_req(sba_pkg::ACT_LOAD, 0, 0, 31, 8'hA5);
    queue_req(sba_pkg::ACT_FIND, 0, 0, 0, 0);
    wait_alloc_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        tail_quiet = 1'b1;
        gap_left   = 0;
        stall_left = 0;
      end
      write_slot_limit(limit_plan[p]);
      queue_alloc_run(RUN_ITEMS);
      wait_alloc_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_slot_bitmap_allocator_core OK");
    end else begin
      $display("tb_slot_bitmap_allocator_core NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(20ms);
    $display("tb_slot_bitmap_allocator_core NOT OK");
    $finish;
  end

endmodule
